FILE: hw/rtl/ptig_pkg.sv
// ----------------------------------------------------------------------------
// ptig_pkg
// Shared types and codes of the primitive-to-triangle index generator.
// ----------------------------------------------------------------------------
package ptig_pkg;

	localparam int OUT_W   = 16;
	localparam int COUNT_W = 16;
	localparam int CMD_W   = 2;
	localparam int PRIM_W  = 3;
	localparam int NRES_W  = 2;
	localparam int MAX_RES = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_BEGIN  = 2'd0,
		CMD_VERTEX = 2'd1,
		CMD_END    = 2'd2
	} cmd_t;

	localparam logic [PRIM_W-1:0] PRIM_TRIANGLES = 3'd0;
	localparam logic [PRIM_W-1:0] PRIM_FAN       = 3'd1;
	localparam logic [PRIM_W-1:0] PRIM_STRIP     = 3'd2;
	localparam logic [PRIM_W-1:0] PRIM_QUADS     = 3'd3;

	// Indices that one vertex produces, in the order they leave the block.
	typedef struct packed {
		logic [NRES_W-1:0]               n;
		logic [MAX_RES-1:0][OUT_W-1:0]   idx;
	} res_t;

	// Occupancy of the result buffer.
	typedef struct packed {
		logic [NRES_W-1:0] n;
		logic [NRES_W-1:0] ptr;
	} stat_t;

endpackage

FILE: hw/rtl/ptig_in_if.sv
// ----------------------------------------------------------------------------
// ptig_in_if
// Command channel: begin, vertex and end transactions.
// ----------------------------------------------------------------------------
interface ptig_in_if;
	logic                         valid;
	logic                         ready;
	logic [ptig_pkg::CMD_W-1:0]   command;
	logic [ptig_pkg::PRIM_W-1:0]  primitive_req;
	logic                         restart_base;

	modport source (output valid, command, primitive_req, restart_base, input ready);
	modport sink (input valid, command, primitive_req, restart_base, output ready);
endinterface

FILE: hw/rtl/ptig_out_if.sv
// ----------------------------------------------------------------------------
// ptig_out_if
// Result channel: one triangle-list index per transaction.
// ----------------------------------------------------------------------------
interface ptig_out_if;
	logic                        valid;
	logic                        ready;
	logic [ptig_pkg::OUT_W-1:0]  vertex_index;
	logic                        last;

	modport source (output valid, vertex_index, last, input ready);
	modport sink (input valid, vertex_index, last, output ready);
endinterface

FILE: hw/rtl/ptig_ctrl.sv
// ----------------------------------------------------------------------------
// ptig_ctrl
// Stream state and index arithmetic for one accepted command.
// ----------------------------------------------------------------------------
module ptig_ctrl #(
	parameter int INDEX_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         accept,
	input  logic [ptig_pkg::CMD_W-1:0]   command,
	input  logic [ptig_pkg::PRIM_W-1:0]  primitive_req,
	input  logic                         restart_base,
	output ptig_pkg::res_t               res
);

	localparam int EXT_W = (INDEX_BITS > ptig_pkg::OUT_W) ? INDEX_BITS : ptig_pkg::OUT_W;

	logic                           active_q;
	logic [ptig_pkg::PRIM_W-1:0]    prim_q;
	logic [ptig_pkg::COUNT_W-1:0]   count_q;
	logic [INDEX_BITS-1:0]          base_q;
	logic [INDEX_BITS-1:0]          next_base_q;

	logic [EXT_W-1:0]       sum;
	logic [INDEX_BITS-1:0]  c, cm1, cm2, cm3;
	logic                   past_three;

	function automatic logic [ptig_pkg::OUT_W-1:0] to_out(input logic [INDEX_BITS-1:0] v);
		logic [EXT_W-1:0] w;
		w = EXT_W'(v);
		return w[ptig_pkg::OUT_W-1:0];
	endfunction

	assign sum        = EXT_W'(base_q) + EXT_W'(count_q);
	assign c          = sum[INDEX_BITS-1:0];
	assign cm1        = c - INDEX_BITS'(1);
	assign cm2        = c - INDEX_BITS'(2);
	assign cm3        = c - INDEX_BITS'(3);
	assign past_three = (|count_q[ptig_pkg::COUNT_W-1:2]) || (&count_q[1:0]);

	always_comb begin
		res     = '0;
		res.n   = ptig_pkg::NRES_W'(1);
		res.idx[0] = to_out(c);
		if (past_three) begin
			case (prim_q)
				ptig_pkg::PRIM_FAN: begin
					res.n      = ptig_pkg::NRES_W'(3);
					res.idx[0] = to_out(base_q);
					res.idx[1] = to_out(cm1);
					res.idx[2] = to_out(c);
				end
				ptig_pkg::PRIM_STRIP: begin
					res.n      = ptig_pkg::NRES_W'(3);
					res.idx[0] = count_q[0] ? to_out(cm1) : to_out(cm2);
					res.idx[1] = count_q[0] ? to_out(cm2) : to_out(cm1);
					res.idx[2] = to_out(c);
				end
				ptig_pkg::PRIM_QUADS: begin
					if (&count_q[1:0]) begin
						res.n      = ptig_pkg::NRES_W'(3);
						res.idx[0] = to_out(cm3);
						res.idx[1] = to_out(cm1);
						res.idx[2] = to_out(c);
					end
				end
				default: begin
				end
			endcase
		end
		// Only a vertex inside an open stream produces indices.
		if (command != ptig_pkg::CMD_VERTEX || !active_q) begin
			res.n = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			prim_q      <= '0;
			count_q     <= '0;
			base_q      <= '0;
			next_base_q <= '0;
		end else if (accept) begin
			case (command)
				ptig_pkg::CMD_BEGIN: begin
					if (!active_q) begin
						active_q <= 1'b1;
						prim_q   <= primitive_req;
						count_q  <= '0;
						base_q   <= restart_base ? '0 : next_base_q;
					end
				end
				ptig_pkg::CMD_VERTEX: begin
					if (active_q) begin
						count_q <= count_q + ptig_pkg::COUNT_W'(1);
					end
				end
				ptig_pkg::CMD_END: begin
					if (active_q) begin
						active_q <= 1'b0;
						if (|count_q) begin
							next_base_q <= c;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/ptig_outq.sv
// ----------------------------------------------------------------------------
// ptig_outq
// Result buffer: a vertex's indices go out one per cycle while out_ready.
// ----------------------------------------------------------------------------
module ptig_outq (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  ptig_pkg::res_t               res,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [ptig_pkg::OUT_W-1:0]   out_index,
	output logic                         out_last,
	output ptig_pkg::stat_t              stat
);

	logic [ptig_pkg::MAX_RES-1:0][ptig_pkg::OUT_W-1:0] idx_s1;
	logic [ptig_pkg::NRES_W-1:0] n_q;
	logic [ptig_pkg::NRES_W-1:0] ptr_q;
	logic                        on_last;
	logic                        load;

	assign on_last   = (ptr_q == n_q - ptig_pkg::NRES_W'(1));
	assign out_valid = (n_q != '0);
	assign in_ready  = !out_valid || (on_last && out_ready);
	assign out_index = idx_s1[ptr_q];
	assign out_last  = on_last;
	assign load      = in_valid && in_ready && (res.n != '0);
	assign stat.n    = n_q;
	assign stat.ptr  = ptr_q;

	always_ff @(posedge clk) begin
		if (load) begin
			idx_s1 <= res.idx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q   <= '0;
			ptr_q <= '0;
		end else if (load) begin
			n_q   <= res.n;
			ptr_q <= '0;
		end else if (out_valid && out_ready) begin
			if (on_last) begin
				n_q   <= '0;
				ptr_q <= '0;
			end else begin
				ptr_q <= ptr_q + ptig_pkg::NRES_W'(1);
			end
		end
	end

endmodule

FILE: hw/rtl/primitive_to_triangle_index_gen.sv
// ----------------------------------------------------------------------------
// primitive_to_triangle_index_gen
// Turns fan, strip and quad vertex streams into triangle-list indices.
// ----------------------------------------------------------------------------
// A begin transaction opens a stream with a primitive type and a base index
// (zero on restart, otherwise the base saved at the end of the last stream
// that held vertices); each vertex transaction then yields its own index,
// base plus position, preceded by two earlier indices that close a triangle
// for fans and strips from their fourth vertex on and for every fourth quad
// vertex; an end transaction closes the stream. The stream state is updated
// in the cycle a command is accepted, and the one to three indices of a
// vertex are registered into a small result buffer that drives the result
// channel, one index per cycle while that channel is ready, with last
// marking the final index of each vertex. A command is accepted whenever
// that buffer is empty or is handing out its final index in the same
// cycle, so it can take the next command while the last index of a vertex
// leaves. Indices wrap at INDEX_BITS bits and leave as their low 16 bits.
// ----------------------------------------------------------------------------
module primitive_to_triangle_index_gen #(
	parameter int INDEX_BITS = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	ptig_in_if.sink         vertices,
	ptig_out_if.source      indices
);

	ptig_pkg::res_t   res;
	ptig_pkg::stat_t  stat;
	logic             accept;

	// A command transaction completes when the buffer can take its results.
	assign accept = vertices.valid && vertices.ready;

	// Stream state and the index arithmetic for the command at the port.
	ptig_ctrl #(
		.INDEX_BITS (INDEX_BITS)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.command       (vertices.command),
		.primitive_req (vertices.primitive_req),
		.restart_base  (vertices.restart_base),
		.res           (res)
	);

	// Result buffer: holds the indices of one vertex and serializes them.
	ptig_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vertices.valid),
		.in_ready  (vertices.ready),
		.res       (res),
		.out_valid (indices.valid),
		.out_ready (indices.ready),
		.out_index (indices.vertex_index),
		.out_last  (indices.last),
		.stat      (stat)
	);

`ifndef SYNTHESIS
	// With indices shown, a command is only taken on a vertex's final index.
	assert property (@(posedge clk) disable iff (!arst_n)
		(vertices.ready && indices.valid) |-> indices.last)
		else $error("command accepted while a vertex still has indices pending");

	// A vertex that produced indices presents them in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && res.n != '0) |=> indices.valid)
		else $error("indices of an accepted vertex not presented");

	// The read pointer stays within the loaded results.
	assert property (@(posedge clk) disable iff (!arst_n)
		indices.valid |-> (stat.ptr < stat.n))
		else $error("result buffer pointer out of range");
`endif

endmodule
